>>> hw/rtl/va3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_pkg
// Shared widths, fixed-point constants and the arctangent table used by the
// vector angle pipeline.
// ----------------------------------------------------------------------------
package va3_pkg;

    localparam int FIELD_W         = 16;
    localparam int DOT_W           = 33;
    localparam int LENGTH_W        = 16;
    localparam int ANGLE_W         = 16;
    localparam int COS_FRAC_BITS   = 30;
    localparam int QUO_BITS        = COS_FRAC_BITS + 1;
    localparam int SQ_W            = 2 * QUO_BITS;
    localparam int SIN_W           = 2 * COS_FRAC_BITS + 1;
    localparam int SINE_ROOT_BITS  = 31;
    localparam int DEG_FRAC_BITS   = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int HALF_TURN_DEG   = 180;
    localparam int SQUARE_POWER    = 2;
    localparam int MAX_ITER        = 32;
    localparam int CORDIC_XW       = 34;
    localparam int CORDIC_ZW       = 26;
    localparam int ATAN_W          = 22;

    localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;
    localparam logic [ANGLE_W-1:0]  ANGLE_MAX  =
        ANGLE_W'(HALF_TURN_DEG << ANGLE_FRAC_BITS);
    localparam logic [QUO_BITS-1:0] ONE_Q      = QUO_BITS'(1) << COS_FRAC_BITS;
    localparam logic [SQ_W-1:0]     ONE_SQ     = SQ_W'(1) << (2 * COS_FRAC_BITS);

    localparam logic signed [CORDIC_ZW-1:0] RIGHT_ANGLE_Z =
        CORDIC_ZW'((HALF_TURN_DEG / SQUARE_POWER) << DEG_FRAC_BITS);
    localparam logic signed [CORDIC_ZW-1:0] HALF_TURN_Z =
        CORDIC_ZW'(HALF_TURN_DEG << DEG_FRAC_BITS);
    localparam logic signed [CORDIC_ZW-1:0] ROUND_Z =
        CORDIC_ZW'(1) << (DEG_FRAC_BITS - ANGLE_FRAC_BITS - 1);

    // atan(2^-i) in degrees, Q6.16
    localparam logic [ATAN_W-1:0] ATAN_DEG [MAX_ITER] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

endpackage

>>> hw/rtl/va3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_if
// Valid/ready channels for vector pairs in and angle results out.
// ----------------------------------------------------------------------------
interface va3_pair_if;
    import va3_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] v1_x;
    logic signed [FIELD_W-1:0] v1_y;
    logic signed [FIELD_W-1:0] v1_z;
    logic signed [FIELD_W-1:0] v2_x;
    logic signed [FIELD_W-1:0] v2_y;
    logic signed [FIELD_W-1:0] v2_z;

    modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, input ready);
    modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, output ready);
endinterface

interface va3_result_if;
    import va3_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DOT_W-1:0]  dot_product;
    logic [LENGTH_W-1:0]      first_length;
    logic [LENGTH_W-1:0]      second_length;
    logic [ANGLE_W-1:0]       angle_degrees;
    logic                     is_parallel;
    logic                     zero_length;

    modport source (output valid, dot_product, first_length, second_length,
                    angle_degrees, is_parallel, zero_length, input ready);
    modport sink   (input valid, dot_product, first_length, second_length,
                    angle_degrees, is_parallel, zero_length, output ready);
endinterface

>>> hw/rtl/va3_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_sqrt
// Pipelined bit-by-bit square root, one result bit per stage, rounded to
// nearest in a last stage. Side data travels alongside.
// ----------------------------------------------------------------------------
module va3_sqrt #(
    parameter int IN_W   = 32,
    parameter int BITS   = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   value,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [BITS:0]     root,
    output logic [SIDE_W-1:0] side_out
);
    localparam int RW = ((IN_W > 2 * BITS) ? IN_W : 2 * BITS) + 2;

    logic [RW-1:0]     rem_reg  [BITS+1];
    logic [BITS-1:0]   root_reg [BITS+1];
    logic [SIDE_W-1:0] side_reg [BITS+2];
    logic [BITS+1:0]   vld_reg;
    logic [BITS:0]     out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BITS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(value);
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < BITS; i++)
    begin : g_step
        localparam int B = BITS - 1 - i;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = (RW'(root_reg[i]) << (B + 1)) | (RW'(1) << (2 * B));
        assign take  = rem_reg[i] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= take ? rem_reg[i] - trial : rem_reg[i];
                root_reg[i+1] <= take ? root_reg[i] | (BITS'(1) << B) : root_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // round half up: remainder above the root means the next integer is closer
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= (BITS + 1)'(root_reg[BITS]) +
                       (BITS + 1)'(rem_reg[BITS] > RW'(root_reg[BITS]));
            side_reg[BITS+1] <= side_reg[BITS];
        end
    end

    assign out_valid = vld_reg[BITS+1];
    assign root      = out_reg;
    assign side_out  = side_reg[BITS+1];
endmodule

>>> hw/rtl/va3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_div
// Pipelined restoring divider for the cosine ratio, one quotient bit per
// stage, saturated to one in Q1.30.
// ----------------------------------------------------------------------------
module va3_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [va3_pkg::QUO_BITS-1:0]  quo,
    output logic [SIDE_W-1:0]             side_out
);
    import va3_pkg::*;

    localparam int DW = ((NUM_W > DEN_W + QUO_BITS) ? NUM_W : DEN_W + QUO_BITS) + 1;

    logic [DW-1:0]       rem_reg  [QUO_BITS+1];
    logic [DEN_W-1:0]    den_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg    [QUO_BITS+1];
    logic                ov_reg   [QUO_BITS+1];
    logic [SIDE_W-1:0]   side_reg [QUO_BITS+2];
    logic [QUO_BITS+1:0] vld_reg;
    logic [QUO_BITS-1:0] out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_BITS:0], in_valid};
        end
    end

    // quotient of 2^31 or more cannot be held, flag it up front
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(num);
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ov_reg[0]   <= DW'(num) >= (DW'(den) << QUO_BITS);
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_step
        localparam int J = QUO_BITS - 1 - i;
        logic [DW-1:0] trial;
        logic          take;

        assign trial = DW'(den_reg[i]) << J;
        assign take  = rem_reg[i] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= take ? rem_reg[i] - trial : rem_reg[i];
                q_reg[i+1]    <= take ? q_reg[i] | (QUO_BITS'(1) << J) : q_reg[i];
                den_reg[i+1]  <= den_reg[i];
                ov_reg[i+1]   <= ov_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= (ov_reg[QUO_BITS] || q_reg[QUO_BITS] > ONE_Q) ?
                       ONE_Q : q_reg[QUO_BITS];
            side_reg[QUO_BITS+1] <= side_reg[QUO_BITS];
        end
    end

    assign out_valid = vld_reg[QUO_BITS+1];
    assign quo       = out_reg;
    assign side_out  = side_reg[QUO_BITS+1];
endmodule

>>> hw/rtl/va3_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_cordic
// Pipelined CORDIC vectoring for atan2(sine, cosine) in degrees, one
// rotation per stage, then clamp to a half turn and round to Q8.8.
// ----------------------------------------------------------------------------
module va3_cordic #(
    parameter int STEPS            = 16,
    parameter int SIDE_W           = 1,
    parameter int SINE_ROOT_BITS_P = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [va3_pkg::QUO_BITS-1:0]  cos_mag,
    input  logic                          cos_neg,
    input  logic [SINE_ROOT_BITS_P-1:0]   sine,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [va3_pkg::ANGLE_W-1:0]   angle,
    output logic [SIDE_W-1:0]             side_out
);
    import va3_pkg::*;

    logic signed [CORDIC_XW-1:0] x_reg    [STEPS+1];
    logic signed [CORDIC_XW-1:0] y_reg    [STEPS+1];
    logic signed [CORDIC_ZW-1:0] z_reg    [STEPS+1];
    logic [SIDE_W-1:0]           side_reg [STEPS+2];
    logic [STEPS+1:0]            vld_reg;
    logic [ANGLE_W-1:0]          out_reg;
    logic                        c_neg;
    logic signed [CORDIC_ZW-1:0] z_clamp;
    logic signed [CORDIC_ZW-1:0] z_round;

    assign c_neg = cos_neg && (cos_mag != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_valid};
        end
    end

    // negative cosine starts a quarter turn ahead with the vector rotated
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= c_neg ? CORDIC_XW'(sine) : CORDIC_XW'(cos_mag);
            y_reg[0]    <= c_neg ? CORDIC_XW'(cos_mag) : CORDIC_XW'(sine);
            z_reg[0]    <= c_neg ? RIGHT_ANGLE_Z : '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CORDIC_XW-1:0] dx;
        logic signed [CORDIC_XW-1:0] dy;
        logic signed [CORDIC_ZW-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = $signed(CORDIC_ZW'(ATAN_DEG[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CORDIC_XW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign z_clamp = (z_reg[STEPS] < 0) ? '0 :
                     (z_reg[STEPS] > HALF_TURN_Z) ? HALF_TURN_Z : z_reg[STEPS];
    assign z_round = z_clamp + ROUND_Z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= z_round[DEG_FRAC_BITS - ANGLE_FRAC_BITS + ANGLE_W - 1:
                               DEG_FRAC_BITS - ANGLE_FRAC_BITS];
            side_reg[STEPS+1] <= side_reg[STEPS];
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign angle     = out_reg;
    assign side_out  = side_reg[STEPS+1];
endmodule

>>> hw/rtl/vector3_angle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_angle_unit
// Dot product, magnitudes and angle in degrees between two 3-D vectors.
// ----------------------------------------------------------------------------
// Fully pipelined: one vector pair is accepted every clock and one result
// leaves every clock while the result channel takes them. Each pair passes
// through the chain of product and sum stages, the magnitude root (one bit
// per stage), the 31-stage cosine divider, the 31-stage sine root and the
// CORDIC rotations (one per stage). The whole pipeline holds while the
// output register is full and not taken; nothing is lost or repeated
// across a stall.
module vector3_angle_unit #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int ITERATION_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    va3_pair_if.sink     pair,
    va3_result_if.source result
);
    import va3_pkg::*;

    localparam int EW    = (COMPONENT_WIDTH > FIELD_W) ? FIELD_W + 1 : COMPONENT_WIDTH;
    localparam int PW    = 2 * EW;
    localparam int SW    = PW + 2;
    localparam int RTW   = ITERATION_STEPS + 1;
    localparam int CMPW  = (RTW > LENGTH_W) ? RTW : LENGTH_W;
    localparam int NUM_W = PW + COS_FRAC_BITS + 1;
    localparam int DEN_W = 2 * LENGTH_W;
    localparam int STEPS = (ITERATION_STEPS > MAX_ITER) ? MAX_ITER : ITERATION_STEPS;
    localparam int DSIDE = SW + 2 * LENGTH_W + 2;
    localparam int TSIDE = SW + 2 * LENGTH_W + 1;
    localparam int SSIDE = QUO_BITS + 1 + TSIDE;

    logic                 en;
    logic [FIELD_W-1:0]   raw  [6];
    logic signed [EW-1:0] comp [6];

    logic                 vld1_reg;
    logic signed [PW-1:0] sq1_reg [3];
    logic signed [PW-1:0] sq2_reg [3];
    logic signed [PW-1:0] cr_reg  [3];

    logic                 vld2_reg;
    logic signed [SW-1:0] dot2_reg;
    logic [PW-1:0]        sa2_reg;
    logic [PW-1:0]        sb2_reg;

    logic                 v_sq1;
    logic                 v_sq2;
    logic [RTW-1:0]       root1;
    logic [RTW-1:0]       root2;
    logic [SW-2:0]        dot_lo;
    logic                 dot_hi;
    logic signed [SW-1:0] dot_w;
    logic [LENGTH_W-1:0]  m1_sat;
    logic [LENGTH_W-1:0]  m2_sat;

    logic                 vld3_reg;
    logic signed [SW-1:0] dot3_reg;
    logic [LENGTH_W-1:0]  m1_3_reg;
    logic [LENGTH_W-1:0]  m2_3_reg;
    logic [DEN_W-1:0]     prod3_reg;
    logic [PW-1:0]        mag3_reg;
    logic                 neg3_reg;
    logic                 zero3_reg;

    logic                 vld4_reg;
    logic [NUM_W-1:0]     num4_reg;
    logic [DEN_W-1:0]     den4_reg;
    logic [DSIDE-1:0]     side4_reg;

    logic                 v_div;
    logic [QUO_BITS-1:0]  quo;
    logic [DSIDE-1:0]     div_side;

    logic                 vld5_reg;
    logic [QUO_BITS-1:0]  q5_reg;
    logic [SQ_W-1:0]      csq5_reg;
    logic [DSIDE-1:0]     side5_reg;

    logic                 vld6_reg;
    logic [SIN_W-1:0]     sin6_reg;
    logic [SSIDE-1:0]     side6_reg;

    logic                     v_sin;
    logic [SINE_ROOT_BITS:0]  sine;
    logic [SSIDE-1:0]         sin_side;

    logic                 v_cor;
    logic [ANGLE_W-1:0]   angle;
    logic [TSIDE-1:0]     cor_side;
    logic signed [SW-1:0] dot_f;
    logic [LENGTH_W-1:0]  m1_f;
    logic [LENGTH_W-1:0]  m2_f;
    logic                 zero_f;

    logic                 out_vld_reg;
    logic signed [DOT_W-1:0] dot_out_reg;
    logic [LENGTH_W-1:0]  m1_out_reg;
    logic [LENGTH_W-1:0]  m2_out_reg;
    logic [ANGLE_W-1:0]   angle_out_reg;
    logic                 par_out_reg;
    logic                 zero_out_reg;

    function automatic logic [LENGTH_W-1:0] sat_len(logic [RTW-1:0] r);
        logic [CMPW-1:0] e;
        begin
            e = CMPW'(r);
            return (e > CMPW'(LENGTH_MAX)) ? LENGTH_MAX : e[LENGTH_W-1:0];
        end
    endfunction

    assign en         = !out_vld_reg || result.ready;
    assign pair.ready = en;

    assign raw[0] = pair.v1_x;
    assign raw[1] = pair.v1_y;
    assign raw[2] = pair.v1_z;
    assign raw[3] = pair.v2_x;
    assign raw[4] = pair.v2_y;
    assign raw[5] = pair.v2_z;

    if (COMPONENT_WIDTH > FIELD_W)
    begin : g_wide
        for (genvar k = 0; k < 6; k++)
        begin : g_comp
            assign comp[k] = $signed({1'b0, raw[k]});
        end
    end
    else
    begin : g_narrow
        for (genvar k = 0; k < 6; k++)
        begin : g_comp
            assign comp[k] = $signed(raw[k][COMPONENT_WIDTH-1:0]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            vld6_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg    <= pair.valid;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= v_sq1;
            vld4_reg    <= vld3_reg;
            vld5_reg    <= v_div;
            vld6_reg    <= vld5_reg;
            out_vld_reg <= v_cor;
        end
    end

    // products, then sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq1_reg[k] <= PW'(comp[k]) * PW'(comp[k]);
                sq2_reg[k] <= PW'(comp[k+3]) * PW'(comp[k+3]);
                cr_reg[k]  <= PW'(comp[k]) * PW'(comp[k+3]);
            end
            dot2_reg <= SW'(cr_reg[0]) + SW'(cr_reg[1]) + SW'(cr_reg[2]);
            sa2_reg  <= $unsigned(sq1_reg[0]) + $unsigned(sq1_reg[1]) +
                        $unsigned(sq1_reg[2]);
            sb2_reg  <= $unsigned(sq2_reg[0]) + $unsigned(sq2_reg[1]) +
                        $unsigned(sq2_reg[2]);
        end
    end

    va3_sqrt #(
        .IN_W   (PW),
        .BITS   (ITERATION_STEPS),
        .SIDE_W (SW - 1)
    ) u_len1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld2_reg),
        .value     (sa2_reg),
        .side_in   (dot2_reg[SW-2:0]),
        .out_valid (v_sq1),
        .root      (root1),
        .side_out  (dot_lo)
    );

    va3_sqrt #(
        .IN_W   (PW),
        .BITS   (ITERATION_STEPS),
        .SIDE_W (1)
    ) u_len2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld2_reg),
        .value     (sb2_reg),
        .side_in   (dot2_reg[SW-1]),
        .out_valid (v_sq2),
        .root      (root2),
        .side_out  (dot_hi)
    );

    assign dot_w  = $signed({dot_hi, dot_lo});
    assign m1_sat = sat_len(root1);
    assign m2_sat = sat_len(root2);

    // length product and the magnitude of the dot product, then the divider operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot3_reg  <= dot_w;
            m1_3_reg  <= m1_sat;
            m2_3_reg  <= m2_sat;
            prod3_reg <= DEN_W'(m1_sat) * DEN_W'(m2_sat);
            mag3_reg  <= dot_w[SW-1] ? PW'(-dot_w) : PW'(dot_w);
            neg3_reg  <= dot_w[SW-1];
            zero3_reg <= (m1_sat == '0) || (m2_sat == '0);

            num4_reg  <= (NUM_W'(mag3_reg) << COS_FRAC_BITS) + NUM_W'(prod3_reg >> 1);
            den4_reg  <= prod3_reg;
            side4_reg <= {dot3_reg, m1_3_reg, m2_3_reg, zero3_reg, neg3_reg};
        end
    end

    va3_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (DSIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld4_reg),
        .num       (num4_reg),
        .den       (den4_reg),
        .side_in   (side4_reg),
        .out_valid (v_div),
        .quo       (quo),
        .side_out  (div_side)
    );

    // sine squared = 1 - cosine squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q5_reg    <= quo;
            csq5_reg  <= SQ_W'(quo) * SQ_W'(quo);
            side5_reg <= div_side;

            sin6_reg  <= SIN_W'(ONE_SQ - csq5_reg);
            side6_reg <= {q5_reg, side5_reg[0], side5_reg[DSIDE-1:1]};
        end
    end

    va3_sqrt #(
        .IN_W   (SIN_W),
        .BITS   (SINE_ROOT_BITS),
        .SIDE_W (SSIDE)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld6_reg),
        .value     (sin6_reg),
        .side_in   (side6_reg),
        .out_valid (v_sin),
        .root      (sine),
        .side_out  (sin_side)
    );

    va3_cordic #(
        .STEPS            (STEPS),
        .SIDE_W           (TSIDE),
        .SINE_ROOT_BITS_P (SINE_ROOT_BITS + 1)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_sin),
        .cos_mag   (sin_side[SSIDE-1 -: QUO_BITS]),
        .cos_neg   (sin_side[TSIDE]),
        .sine      (sine),
        .side_in   (sin_side[TSIDE-1:0]),
        .out_valid (v_cor),
        .angle     (angle),
        .side_out  (cor_side)
    );

    assign dot_f  = $signed(cor_side[TSIDE-1 -: SW]);
    assign m1_f   = cor_side[2*LENGTH_W:LENGTH_W+1];
    assign m2_f   = cor_side[LENGTH_W:1];
    assign zero_f = cor_side[0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_out_reg   <= DOT_W'(dot_f);
            m1_out_reg    <= m1_f;
            m2_out_reg    <= m2_f;
            angle_out_reg <= zero_f ? '0 : angle;
            par_out_reg   <= !zero_f && (angle == '0);
            zero_out_reg  <= zero_f;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.dot_product   = dot_out_reg;
    assign result.first_length  = m1_out_reg;
    assign result.second_length = m2_out_reg;
    assign result.angle_degrees = angle_out_reg;
    assign result.is_parallel   = par_out_reg;
    assign result.zero_length   = zero_out_reg;

`ifndef ASSERT_OFF
    a_len_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        v_sq1 == v_sq2)
        else $error("magnitude pipelines out of step");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_length |->
            result.angle_degrees == '0 && !result.is_parallel)
        else $error("zero-length item with angle or parallel flag");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.angle_degrees <= ANGLE_MAX)
        else $error("angle above half turn");

    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_parallel |-> result.angle_degrees == '0)
        else $error("parallel flag with nonzero angle");
`endif

endmodule
